@@ src/nfb_pkg.sv @@
`timescale 1ns / 1ps
package nfb_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE_PIXEL  = 2'd0,
        CMD_REFRESH_LINE = 2'd1,
        CMD_CLEAR_PANEL  = 2'd2,
        CMD_FILL         = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  x_pos;
        logic [7:0]  y_pos;
        logic [3:0]  colour;
    } item_t;

    typedef struct packed {
        logic [31:0] frame_word;
        logic [2:0]  byte_count;
        logic        frame_last;
    } result_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_MODE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_OPCODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_OPCODE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_COLOUR = 2'd3;

    localparam logic       DIFF_MODE_RST         = 1'b1;
    localparam logic [7:0] UPDATE_OPCODE_RST     = 8'd144;
    localparam logic [7:0] CLEAR_OPCODE_RST      = 8'd32;
    localparam logic [3:0] BACKGROUND_COLOUR_RST = 4'd0;

    typedef struct packed {
        logic load;
        logic clr_cnt;
        logic sweep;
        logic pix_rd;
        logic pix_wr;
        logic cmp;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic line_ok;
        logic diff_mode;
        logic cmp_last;
        logic differ;
        logic emit_last;
    } dp_status_t;

endpackage

@@ src/nfb_ram.sv @@
`timescale 1ns / 1ps
module nfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/nfb_ctrl.sv @@
`timescale 1ns / 1ps
module nfb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  nfb_pkg::cmd_t       command,
    input  nfb_pkg::dp_status_t status,
    output nfb_pkg::ctrl_cmd_t  cmd,
    output logic                busy
);

    typedef enum logic [7:0] {
        ST_SWEEP   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_PIX_RD  = 8'b0000_0100,
        ST_PIX_WR  = 8'b0000_1000,
        ST_REF_CHK = 8'b0001_0000,
        ST_CMP     = 8'b0010_0000,
        ST_CMP_END = 8'b0100_0000,
        ST_EMIT    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.clr_cnt = 1'b1;
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (command)
                        nfb_pkg::CMD_WRITE_PIXEL:  state_next = ST_PIX_RD;
                        nfb_pkg::CMD_REFRESH_LINE: state_next = ST_REF_CHK;
                        nfb_pkg::CMD_CLEAR_PANEL:  state_next = ST_EMIT;
                        nfb_pkg::CMD_FILL:         state_next = ST_SWEEP;
                        default:                   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIX_RD:
            begin
                cmd.pix_rd = 1'b1;
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR:
            begin
                cmd.pix_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_REF_CHK:
            begin
                cmd.clr_cnt = 1'b1;
                if (!status.line_ok)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.diff_mode)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_CMP:
            begin
                cmd.cmp = 1'b1;
                if (status.cmp_last)
                begin
                    state_next = ST_CMP_END;
                end
            end
            ST_CMP_END:
            begin
                cmd.clr_cnt = 1'b1;
                state_next  = status.differ ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not make block busy");

    a_emit_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP_END && status.differ |=> state_reg == ST_EMIT)
        else $error("changed line not sent");

endmodule

@@ src/nfb_datapath.sv @@
`timescale 1ns / 1ps
module nfb_datapath #(
    parameter int PANEL_WIDTH  = 176,
    parameter int PANEL_HEIGHT = 176
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nfb_pkg::item_t                    item,
    input  nfb_pkg::ctrl_cmd_t                cmd,
    output nfb_pkg::dp_status_t               status,
    input  logic                              cfg_valid,
    input  logic [nfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nfb_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              result_valid,
    output nfb_pkg::result_t                  result
);

    localparam int LINE_BYTES  = (PANEL_WIDTH + 1) / 2;
    localparam int BUF_DEPTH   = LINE_BYTES * PANEL_HEIGHT;
    localparam int FRAME_BYTES = LINE_BYTES + 4;
    localparam int ADDR_W      = $clog2(BUF_DEPTH);
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [ADDR_W-1:0] LB_A       = ADDR_W'(LINE_BYTES);
    localparam logic [ADDR_W-1:0] BUF_LAST   = ADDR_W'(BUF_DEPTH - 1);
    localparam logic [IDX_W-1:0]  LB_I       = IDX_W'(LINE_BYTES);
    localparam logic [IDX_W-1:0]  DATA_END_I = IDX_W'(LINE_BYTES + 1);
    localparam logic [IDX_W-1:0]  FRAME_LAST = IDX_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0]  CLEAR_LAST = IDX_W'(1);
    localparam logic [7:0]        X_LIMIT    = 8'(PANEL_WIDTH);
    localparam logic [7:0]        Y_LIMIT    = 8'(PANEL_HEIGHT);

    logic                diff_mode_reg;
    logic [7:0]          update_opcode_reg;
    logic [7:0]          clear_opcode_reg;
    logic [3:0]          background_colour_reg;

    nfb_pkg::cmd_t       cmd_reg;
    logic [7:0]          x_reg;
    logic [7:0]          y_reg;
    logic [3:0]          colour_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [7:0]          fill_byte_reg;

    logic [ADDR_W-1:0]   sweep_cnt_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [1:0]          wcnt_reg;
    logic [23:0]         word_reg;
    logic                diff_reg;

    logic                result_valid_reg;
    nfb_pkg::result_t    result_reg;

    logic [ADDR_W-1:0]   pix_addr;
    logic [IDX_W-1:0]    rd_off;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   draw_wr_addr;
    logic [ADDR_W-1:0]   shown_wr_addr;
    logic [7:0]          draw_wr_data;
    logic [7:0]          shown_wr_data;
    logic                draw_we;
    logic                shown_we;
    logic [7:0]          rd_draw;
    logic [7:0]          rd_shown;

    logic                is_clear;
    logic                pix_ok;
    logic                in_data;
    logic [IDX_W-1:0]    emit_last_idx;
    logic                last_byte;
    logic [7:0]          cur_byte;
    logic [31:0]         cur_word;
    logic                word_out;
    logic [31:0]         out_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_mode_reg         <= nfb_pkg::DIFF_MODE_RST;
            update_opcode_reg     <= nfb_pkg::UPDATE_OPCODE_RST;
            clear_opcode_reg      <= nfb_pkg::CLEAR_OPCODE_RST;
            background_colour_reg <= nfb_pkg::BACKGROUND_COLOUR_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                nfb_pkg::CFG_DIFF_MODE:         diff_mode_reg         <= cfg_data[0];
                nfb_pkg::CFG_UPDATE_OPCODE:     update_opcode_reg     <= cfg_data;
                nfb_pkg::CFG_CLEAR_OPCODE:      clear_opcode_reg      <= cfg_data;
                nfb_pkg::CFG_BACKGROUND_COLOUR: background_colour_reg <= cfg_data[3:0];
                default:                        ;
            endcase
        end
    end

    // latch the command; reset sweep writes zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= nfb_pkg::CMD_WRITE_PIXEL;
            fill_byte_reg <= 8'h00;
        end
        else if (cmd.load)
        begin
            cmd_reg <= item.command;
            if (item.command == nfb_pkg::CMD_FILL)
            begin
                fill_byte_reg <= {background_colour_reg, background_colour_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg      <= item.x_pos;
            y_reg      <= item.y_pos;
            colour_reg <= item.colour;
            base_reg   <= ADDR_W'(item.y_pos) * LB_A;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            idx_reg       <= '0;
            wcnt_reg      <= '0;
            diff_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clr_cnt)
            begin
                sweep_cnt_reg <= '0;
                idx_reg       <= '0;
                wcnt_reg      <= '0;
                diff_reg      <= 1'b0;
            end
            else
            begin
                if (cmd.sweep)
                begin
                    sweep_cnt_reg <= status.sweep_last ? '0 : sweep_cnt_reg + 1'b1;
                end
                if (cmd.cmp || cmd.emit)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (cmd.cmp && idx_reg != '0 && rd_draw != rd_shown)
                begin
                    diff_reg <= 1'b1;
                end
                if (cmd.emit)
                begin
                    wcnt_reg <= word_out ? 2'd0 : wcnt_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            word_reg <= cur_word[23:0];
        end
    end

    assign is_clear      = (cmd_reg == nfb_pkg::CMD_CLEAR_PANEL);
    assign pix_ok        = (x_reg < X_LIMIT) && (y_reg < Y_LIMIT);
    assign pix_addr      = base_reg + ADDR_W'(x_reg[7:1]);
    assign in_data       = (idx_reg >= IDX_W'(2)) && (idx_reg <= DATA_END_I);
    assign emit_last_idx = is_clear ? CLEAR_LAST : FRAME_LAST;
    assign last_byte     = (idx_reg == emit_last_idx);

    always_comb
    begin
        rd_off = '0;
        if (cmd.cmp && idx_reg < LB_I)
        begin
            rd_off = idx_reg;
        end
        else if (cmd.emit && idx_reg != '0 && idx_reg <= LB_I)
        begin
            rd_off = idx_reg - 1'b1;
        end
    end

    assign rd_addr = cmd.pix_rd ? pix_addr : base_reg + ADDR_W'(rd_off);

    always_comb
    begin
        if (cmd.sweep)
        begin
            draw_we       = 1'b1;
            draw_wr_addr  = sweep_cnt_reg;
            draw_wr_data  = fill_byte_reg;
            shown_we      = 1'b1;
            shown_wr_addr = sweep_cnt_reg;
            shown_wr_data = fill_byte_reg;
        end
        else
        begin
            draw_we       = cmd.pix_wr && pix_ok;
            draw_wr_addr  = pix_addr;
            draw_wr_data  = x_reg[0] ? {rd_draw[7:4], colour_reg}
                                     : {colour_reg, rd_draw[3:0]};
            shown_we      = cmd.emit && !is_clear && diff_mode_reg && in_data;
            shown_wr_addr = base_reg + ADDR_W'(idx_reg - IDX_W'(2));
            shown_wr_data = rd_draw;
        end
    end

    nfb_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_draw_ram (
        .clk     (clk),
        .we      (draw_we),
        .wr_addr (draw_wr_addr),
        .wr_data (draw_wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_draw)
    );

    nfb_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_shown_ram (
        .clk     (clk),
        .we      (shown_we),
        .wr_addr (shown_wr_addr),
        .wr_data (shown_wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_shown)
    );

    always_comb
    begin
        if (idx_reg == '0)
        begin
            cur_byte = is_clear ? clear_opcode_reg : update_opcode_reg;
        end
        else if (idx_reg == IDX_W'(1))
        begin
            cur_byte = is_clear ? 8'h00 : y_reg + 8'd1;
        end
        else if (in_data)
        begin
            cur_byte = rd_draw;
        end
        else
        begin
            cur_byte = 8'h00;
        end
    end

    assign cur_word = {word_reg, cur_byte};
    assign word_out = (wcnt_reg == 2'd3) || last_byte;

    always_comb
    begin
        case (wcnt_reg)
            2'd0:    out_word = {cur_word[7:0], 24'h0};
            2'd1:    out_word = {cur_word[15:0], 16'h0};
            2'd2:    out_word = {cur_word[23:0], 8'h0};
            default: out_word = cur_word;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit && word_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && word_out)
        begin
            result_reg.frame_word <= out_word;
            result_reg.byte_count <= {1'b0, wcnt_reg} + 3'd1;
            result_reg.frame_last <= last_byte;
        end
    end

    assign status.sweep_last = (sweep_cnt_reg == BUF_LAST);
    assign status.line_ok    = (y_reg < Y_LIMIT);
    assign status.diff_mode  = diff_mode_reg;
    assign status.cmp_last   = (idx_reg == LB_I);
    assign status.differ     = diff_reg;
    assign status.emit_last  = last_byte;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_cnt_reg <= BUF_LAST)
        else $error("sweep address past end of buffer");

    a_emit_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> idx_reg <= emit_last_idx)
        else $error("byte index past end of frame");

    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.frame_last |-> result_reg.byte_count == 3'd4)
        else $error("short word before end of frame");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> result_reg.byte_count != 3'd0 && result_reg.byte_count <= 3'd4)
        else $error("byte count out of range");

endmodule

@@ src/nibble_framebuffer_line_refresher_top.sv @@
`timescale 1ns / 1ps
// 4-bit-per-pixel frame buffer with a shadow copy of the panel contents.
// Command channel: item is taken on a clock edge with start high and busy low.
//   write pixel: read-modify-write of one byte, no result.
//   refresh line: a line check, plus a compare against the shown copy in diff mode,
//     plus the send when the line goes out; one byte per cycle through the draw
//     memory read port, four bytes packed to a word.
//   all clear: one word.
//   fill: one memory entry per cycle over all LINE_BYTES*PANEL_HEIGHT entries.
// Result channel: result_valid pulses for one cycle per packed word, first
// byte in bits 31..24, registered in the cycle after the byte that completes it; the
// receiver has no way to stall and must take every word.
// Configuration channel: cfg_ready is always high; write only while idle.
// Reset: both buffers are cleared to black by a sweep over all
// LINE_BYTES*PANEL_HEIGHT entries (15488 at 176x176), with busy high.
module nibble_framebuffer_line_refresher_top #(
    parameter int PANEL_WIDTH  = 176,
    parameter int PANEL_HEIGHT = 176
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  nfb_pkg::item_t                    item,
    output logic                              result_valid,
    output nfb_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nfb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    nfb_pkg::ctrl_cmd_t  cmd;
    nfb_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    nfb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (item.command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    nfb_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
